/* rtl/twgd_pkg.sv */
// ----------------------------------------------------------------------------
// twgd_pkg: shared types and constants of the touch wake gesture detector
// State codes, configuration register indexes and gesture limits.
// ----------------------------------------------------------------------------
package twgd_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_S2W_ENABLE       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DT2W_ENABLE      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DT2W_FULL_SCREEN = 3'd4;

  // Gesture limits (coordinate limits fit the widest coordinate)
  localparam int LIMIT_COORD_BITS = 16;
  localparam logic [LIMIT_COORD_BITS-1:0] SWEEP_MAX_DY = 16'd200;
  localparam logic [LIMIT_COORD_BITS-1:0] TAP_MAX_DIST = 16'd150;

  // Tap phase window in microseconds (fits the narrowest timestamp)
  localparam int LIMIT_TIME_BITS = 32;
  localparam logic [LIMIT_TIME_BITS-1:0] TAP_MIN_US = 32'd5000;
  localparam logic [LIMIT_TIME_BITS-1:0] TAP_MAX_US = 32'd250000;

  // Sweep machine states
  typedef enum logic [3:0] {
    SW_IDLE  = 4'b0001,
    SW_DOWN  = 4'b0010,
    SW_VALID = 4'b0100,
    SW_INVAL = 4'b1000
  } sweep_state_t;

  // Double-tap machine states
  typedef enum logic [3:0] {
    DT_IDLE  = 4'b0001,
    DT_DOWN1 = 4'b0010,
    DT_UP    = 4'b0100,
    DT_DOWN2 = 4'b1000
  } tap_state_t;

endpackage

/* rtl/touch_wake_gesture_detector.sv */
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector: wake gestures from a stream of touch reports
// Sweep and double-tap detection between an input register and a result
// register.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (in_valid / in_stall) is one touch
//   report: touching, x_pos, y_pos and time_us. Every report gives exactly
//   one result on the output channel (out_valid / out_stall): wake,
//   sweep_done and double_tap_done.
//   The report is registered at the input, and both gesture machines step
//   as it moves into the result register.
//   Throughput is one report per cycle while the receiver does not stall;
//   it is set by the step of the two gesture machines, once per report.
//   When the receiver stalls, the result register holds its value and the
//   input register keeps one more report; in_stall then rises until the
//   result is taken.
//   Reset (rst, synchronous) clears both machines to idle, empties both
//   registers and clears all configuration registers, so both gestures
//   start disabled. The user writes configuration through cfg_we / cfg_index /
//   cfg_data only while no report is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module touch_wake_gesture_detector
  import twgd_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  // Touch reports
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      touching,
  input  logic [COORD_BITS-1:0]     x_pos,
  input  logic [COORD_BITS-1:0]     y_pos,
  input  logic [TIME_BITS-1:0]      time_us,
  // Results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      wake,
  output logic                      sweep_done,
  output logic                      double_tap_done
);

  logic [COORD_BITS-1:0] screen_width;
  logic [COORD_BITS-1:0] screen_height;
  logic                  s2w_enable;
  logic                  dt2w_enable;
  logic                  dt2w_full_screen;

  logic                  rep_valid;
  logic                  rep_touching;
  logic [COORD_BITS-1:0] rep_x;
  logic [COORD_BITS-1:0] rep_y;
  logic [TIME_BITS-1:0]  rep_time;

  logic                  advance;
  logic                  accept;
  logic                  sweep_fire;
  logic                  tap_fire;
  logic                  sweep_hit;
  logic                  tap_hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= '0;
      screen_height    <= '0;
      s2w_enable       <= 1'b0;
      dt2w_enable      <= 1'b0;
      dt2w_full_screen <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:     screen_width     <= cfg_data;
        CFG_SCREEN_HEIGHT:    screen_height    <= cfg_data;
        CFG_S2W_ENABLE:       s2w_enable       <= cfg_data[0];
        CFG_DT2W_ENABLE:      dt2w_enable      <= cfg_data[0];
        CFG_DT2W_FULL_SCREEN: dt2w_full_screen <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: move the held report on whenever the result register frees up
  assign advance  = rep_valid && (!out_valid || !out_stall);
  assign in_stall = rep_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (accept) begin
      rep_valid <= 1'b1;
    end else if (advance) begin
      rep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rep_touching <= touching;
      rep_x        <= x_pos;
      rep_y        <= y_pos;
      rep_time     <= time_us;
    end
  end

  // Gesture machines step once per report while enabled
  twgd_sweep #(
    .COORD_BITS(COORD_BITS)
  ) u_sweep (
    .clk          (clk),
    .rst          (rst),
    .step         (advance && s2w_enable),
    .down         (rep_touching),
    .x_pos        (rep_x),
    .y_pos        (rep_y),
    .screen_width (screen_width),
    .fire         (sweep_fire)
  );

  twgd_tap #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_tap (
    .clk           (clk),
    .rst           (rst),
    .step          (advance && dt2w_enable),
    .touching      (rep_touching),
    .x_pos         (rep_x),
    .y_pos         (rep_y),
    .time_us       (rep_time),
    .screen_height (screen_height),
    .full_screen   (dt2w_full_screen),
    .fire          (tap_fire)
  );

  assign sweep_hit = sweep_fire && s2w_enable;
  assign tap_hit   = tap_fire && dt2w_enable;

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wake            <= sweep_hit || tap_hit;
      sweep_done      <= sweep_hit;
      double_tap_done <= tap_hit;
    end
  end

endmodule

/* rtl/twgd_sweep.sv */
// ----------------------------------------------------------------------------
// twgd_sweep: horizontal sweep gesture machine
// Tracks one touch from its first point and flags a release after a wide,
// flat horizontal move.
// ----------------------------------------------------------------------------
module twgd_sweep
  import twgd_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  down,
  input  logic [COORD_BITS-1:0] x_pos,
  input  logic [COORD_BITS-1:0] y_pos,
  input  logic [COORD_BITS-1:0] screen_width,
  output logic                  fire
);

  sweep_state_t          state;
  sweep_state_t          state_next;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] half_width;

  // Distances from the start point
  assign dx = (x_pos >= start_x) ? x_pos - start_x : start_x - x_pos;
  assign dy = (y_pos >= start_y) ? y_pos - start_y : start_y - y_pos;
  assign half_width = screen_width >> 1;

  // Next state and release detection
  always_comb begin
    state_next = down ? SW_DOWN : SW_IDLE;
    fire       = 1'b0;
    case (state)
      SW_IDLE: begin
      end
      SW_DOWN, SW_VALID: begin
        fire = (state == SW_VALID) && !down;
        if (down) begin
          if (LIMIT_COORD_BITS'(dy) > SWEEP_MAX_DY) begin
            state_next = SW_INVAL;
          end else if (dx > half_width) begin
            state_next = SW_VALID;
          end
        end
      end
      SW_INVAL: begin
        if (down) begin
          state_next = SW_INVAL;
        end
      end
      default: begin
        state_next = SW_IDLE;
      end
    endcase
  end

  // Advance the machine and latch the start point on first contact
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SW_IDLE;
      start_x <= '0;
      start_y <= '0;
    end else if (step) begin
      state <= state_next;
      if (state == SW_IDLE && down) begin
        start_x <= x_pos;
        start_y <= y_pos;
      end
    end
  end

endmodule

/* rtl/twgd_tap.sv */
// ----------------------------------------------------------------------------
// twgd_tap: double-tap gesture machine
// Times each tap phase against a fixed window and checks that the second
// tap lands near the first.
// ----------------------------------------------------------------------------
module twgd_tap
  import twgd_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  touching,
  input  logic [COORD_BITS-1:0] x_pos,
  input  logic [COORD_BITS-1:0] y_pos,
  input  logic [TIME_BITS-1:0]  time_us,
  input  logic [COORD_BITS-1:0] screen_height,
  input  logic                  full_screen,
  output logic                  fire
);

  tap_state_t            state;
  tap_state_t            state_next;
  logic [TIME_BITS-1:0]  last_change_us;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [TIME_BITS-1:0]  elapsed;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  down;
  logic                  time_ok;
  logic                  near;

  // Upper-half touches count as no touch unless the whole screen is active
  assign down = touching && (full_screen || !(y_pos < (screen_height >> 1)));

  // Phase length, wrapping at the timestamp width
  assign elapsed = time_us - last_change_us;
  assign time_ok = (elapsed > TIME_BITS'(TAP_MIN_US)) &&
                   (elapsed < TIME_BITS'(TAP_MAX_US));

  // Distance of this touch from the first tap
  assign dx   = (x_pos >= start_x) ? x_pos - start_x : start_x - x_pos;
  assign dy   = (y_pos >= start_y) ? y_pos - start_y : start_y - y_pos;
  assign near = (LIMIT_COORD_BITS'(dx) < TAP_MAX_DIST) &&
                (LIMIT_COORD_BITS'(dy) < TAP_MAX_DIST);

  // Next state and second-release detection
  always_comb begin
    state_next = down ? DT_DOWN1 : DT_IDLE;
    fire       = 1'b0;
    case (state)
      DT_IDLE: begin
      end
      DT_DOWN1: begin
        if (!down && time_ok) begin
          state_next = DT_UP;
        end
      end
      DT_UP: begin
        if (down) begin
          if (time_ok && near) begin
            state_next = DT_DOWN2;
          end
        end else begin
          state_next = DT_UP;
        end
      end
      DT_DOWN2: begin
        if (!down) begin
          if (time_ok) begin
            fire = 1'b1;
          end else begin
            state_next = DT_UP;
          end
        end else begin
          state_next = DT_DOWN2;
        end
      end
      default: begin
        state_next = DT_IDLE;
      end
    endcase
  end

  // Advance; stamp the time of every change and the point of a first tap
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= DT_IDLE;
      last_change_us <= '0;
      start_x        <= '0;
      start_y        <= '0;
    end else if (step) begin
      state <= state_next;
      if (state_next != state) begin
        last_change_us <= time_us;
        if (state_next == DT_DOWN1) begin
          start_x <= x_pos;
          start_y <= y_pos;
        end
      end
    end
  end

endmodule

/* bench/touch_wake_gesture_detector_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_wake_gesture_detector_test: self-checking bench for the gesture block
// Drives touch reports through the valid/stall request channel, predicts the
// sweep and double-tap outcome of every report with a cycle-free model of both
// gesture machines, and checks each result in order. Directed gesture cases
// come first, then randomized sweeps, double taps and noise under several
// screen settings, mostly with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module touch_wake_gesture_detector_test;
  import twgd_pkg::*;

  localparam int COORD_W     = 12;
  localparam int STAMP_W     = 48;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 125;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic wake;
    logic sweep;
    logic tap;
  } verdict_t;

  // Ports of the block
  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      touching  = 1'b0;
  logic [COORD_W-1:0]        x_pos     = '0;
  logic [COORD_W-1:0]        y_pos     = '0;
  logic [STAMP_W-1:0]        time_us   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      wake;
  logic                      sweep_done;
  logic                      double_tap_done;

  // Bench state
  verdict_t    pending_verdicts[$];
  int unsigned reports_sent = 0;
  int unsigned mismatches   = 0;
  bit          jitter       = 1'b0;
  stamp_t      now_us       = '0;

  // Shadow configuration
  coord_t width_cfg  = '0;
  coord_t height_cfg = '0;
  bit     s2w_on     = 1'b0;
  bit     dt2w_on    = 1'b0;
  bit     full_on    = 1'b0;

  // Shadow gesture state
  sweep_state_t sw_phase  = SW_IDLE;
  coord_t       sw_x0     = '0;
  coord_t       sw_y0     = '0;
  tap_state_t   tap_phase = DT_IDLE;
  stamp_t       tap_mark  = '0;
  coord_t       tap_x0    = '0;
  coord_t       tap_y0    = '0;

  touch_wake_gesture_detector #(
    .COORD_BITS(COORD_W),
    .TIME_BITS (STAMP_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .touching       (touching),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .time_us        (time_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .wake           (wake),
    .sweep_done     (sweep_done),
    .double_tap_done(double_tap_done)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Gesture prediction
  // ------------------------------------------------------------------------
  function automatic coord_t coord_dist(coord_t a, coord_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Elapsed time since the last tap phase change wraps at the stamp width
  function automatic bit window_ok(stamp_t stamp);
    stamp_t span;
    span = stamp - tap_mark;
    return (span > stamp_t'(TAP_MIN_US)) && (span < stamp_t'(TAP_MAX_US));
  endfunction

  function automatic bit step_sweep(bit down, coord_t x, coord_t y);
    sweep_state_t nxt = down ? SW_DOWN : SW_IDLE;
    bit fire = 1'b0;
    case (sw_phase)
      SW_IDLE: begin
        if (down) begin
          sw_x0 = x;
          sw_y0 = y;
        end
      end
      SW_DOWN, SW_VALID: begin
        if (sw_phase == SW_VALID && !down) fire = 1'b1;
        // Re-judge every report against the start point
        if (down) begin
          if (LIMIT_COORD_BITS'(coord_dist(y, sw_y0)) > SWEEP_MAX_DY) nxt = SW_INVAL;
          else if (coord_dist(x, sw_x0) > (width_cfg >> 1)) nxt = SW_VALID;
        end
      end
      default: begin
        if (down) nxt = SW_INVAL;
      end
    endcase
    sw_phase = nxt;
    return fire;
  endfunction

  function automatic bit step_tap(bit down, coord_t x, coord_t y, stamp_t stamp);
    bit         present;
    tap_state_t nxt;
    bit         fire;
    fire = 1'b0;
    // Upper half counts as no touch unless full-screen taps are on
    present = down && (full_on || y >= (height_cfg >> 1));
    nxt = present ? DT_DOWN1 : DT_IDLE;
    case (tap_phase)
      DT_IDLE: ;
      DT_DOWN1: begin
        if (!present && window_ok(stamp)) nxt = DT_UP;
      end
      DT_UP: begin
        if (present) begin
          if (window_ok(stamp) &&
              LIMIT_COORD_BITS'(coord_dist(x, tap_x0)) < TAP_MAX_DIST &&
              LIMIT_COORD_BITS'(coord_dist(y, tap_y0)) < TAP_MAX_DIST) nxt = DT_DOWN2;
        end else begin
          nxt = DT_UP;
        end
      end
      default: begin
        if (!present) begin
          if (window_ok(stamp)) fire = 1'b1;
          else nxt = DT_UP;
        end else begin
          nxt = DT_DOWN2;
        end
      end
    endcase
    // Restart the phase clock on every change, latch position on a first tap
    if (nxt != tap_phase) begin
      tap_mark = stamp;
      if (nxt == DT_DOWN1) begin
        tap_x0 = x;
        tap_y0 = y;
      end
    end
    tap_phase = nxt;
    return fire;
  endfunction

  function automatic verdict_t predict_gesture(bit down, coord_t x, coord_t y,
                                               stamp_t stamp);
    verdict_t v;
    v.sweep = s2w_on ? step_sweep(down, x, y) : 1'b0;
    v.tap   = dt2w_on ? step_tap(down, x, y, stamp) : 1'b0;
    v.wake  = v.sweep | v.tap;
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // Channel activity
  // ------------------------------------------------------------------------
  // Mostly no pause, some short ones, a few long ones
  function automatic int unsigned pick_delay();
    int unsigned r;
    if (!jitter) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Stall the result channel at random
  initial begin
    forever begin
      @(posedge clk);
      if (jitter && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (1 + pick_delay()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // Check each accepted result against the oldest prediction
  initial begin
    verdict_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result with no report pending: wake=%0b sweep=%0b tap=%0b",
                                  wake, sweep_done, double_tap_done));
        end else begin
          want = pending_verdicts.pop_front();
          if (wake !== want.wake || sweep_done !== want.sweep ||
              double_tap_done !== want.tap)
            flag_mismatch($sformatf(
              "expected wake=%0b sweep=%0b tap=%0b, got wake=%0b sweep=%0b tap=%0b",
              want.wake, want.sweep, want.tap, wake, sweep_done, double_tap_done));
        end
      end
    end
  end

  // Offer one report and hold it until the request is taken
  task automatic send_report(bit down, coord_t x, coord_t y, stamp_t stamp);
    int unsigned gap;
    gap = pick_delay();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    touching <= down;
    x_pos    <= x;
    y_pos    <= y;
    time_us  <= stamp;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(predict_gesture(down, x, y, stamp));
    reports_sent++;
  endtask

  // Advance the time base, then send
  task automatic report(bit down, coord_t x, coord_t y, int unsigned step_us);
    now_us = now_us + stamp_t'(step_us);
    send_report(down, x, y, now_us);
  endtask

  // Stop requests and wait for every predicted result
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, coord_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH:     width_cfg  = value;
      CFG_SCREEN_HEIGHT:    height_cfg = value;
      CFG_S2W_ENABLE:       s2w_on     = value[0];
      CFG_DT2W_ENABLE:      dt2w_on    = value[0];
      CFG_DT2W_FULL_SCREEN: full_on    = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(coord_t width, coord_t height, bit sweep_on, bit tap_on,
                           bit anywhere);
    drain_reports();
    write_reg(CFG_SCREEN_WIDTH, width);
    write_reg(CFG_SCREEN_HEIGHT, height);
    write_reg(CFG_S2W_ENABLE, coord_t'(sweep_on));
    write_reg(CFG_DT2W_ENABLE, coord_t'(tap_on));
    write_reg(CFG_DT2W_FULL_SCREEN, coord_t'(anywhere));
  endtask

  // ------------------------------------------------------------------------
  // Random gesture generators
  // ------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, 4095));
  endfunction

  // Move a coordinate by up to span either way, clamped to the coordinate range
  function automatic coord_t nudge(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_resolution();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return coord_t'($urandom_range(480, 1440));
      default: return rand_coord();
    endcase
  endfunction

  // Tap phase length: mostly inside the window, some on its edges or outside
  function automatic int unsigned tap_phase_us();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(6000, 240000);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return 5000;
        1:       return 5001;
        2:       return 249999;
        default: return 250000;
      endcase
    end
    if (r < 90) return $urandom_range(0, 5000);
    return $urandom_range(250000, 600000);
  endfunction

  task automatic random_sweep();
    coord_t x0, y0, xt;
    int     moves, i;
    x0 = rand_coord();
    y0 = rand_coord();
    xt = rand_coord();
    moves = $urandom_range(1, 5);
    report(1'b1, x0, y0, $urandom_range(1000, 100000));
    for (i = 1; i <= moves; i++)
      report(1'b1, coord_t'(int'(x0) + (int'(xt) - int'(x0)) * i / moves),
             nudge(y0, ($urandom_range(0, 9) == 0) ? 300 : 150),
             $urandom_range(1000, 30000));
    report(1'b0, rand_coord(), rand_coord(), $urandom_range(1000, 50000));
  endtask

  task automatic random_double_tap();
    coord_t x0, y0, x1, y1;
    x0 = rand_coord();
    // Favor the lower half when only that half takes taps
    if (!full_on && $urandom_range(0, 9) < 8)
      y0 = coord_t'($urandom_range(height_cfg >> 1, 4095));
    else
      y0 = rand_coord();
    x1 = nudge(x0, 170);
    y1 = nudge(y0, 170);
    report(1'b1, x0, y0, tap_phase_us());
    report(1'b0, rand_coord(), rand_coord(), tap_phase_us());
    report(1'b1, x1, y1, tap_phase_us());
    if ($urandom_range(0, 3) == 0)
      report(1'b1, nudge(x1, 50), nudge(y1, 50), $urandom_range(0, 3000));
    report(1'b0, rand_coord(), rand_coord(), tap_phase_us());
  endtask

  task automatic random_noise();
    int n, i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      // Jump the time base now and then so every stamp bit toggles
      if ($urandom_range(0, 9) == 0) now_us = stamp_t'({$urandom(), $urandom()});
      report(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
             $urandom_range(0, 400000));
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Both machines start disabled: full gestures must stay silent
  task automatic test_disabled_after_reset();
    report(1'b1, '0, '0, 10000);
    report(1'b1, '1, '1, 20000);
    report(1'b0, '1, '0, 20000);
  endtask

  task automatic test_sweep_and_double_tap();
    configure('1, '1, 1'b1, 1'b1, 1'b0);
    // Start close to the top of the stamp range so the first tap wraps
    now_us = stamp_t'(0) - stamp_t'(100000);
    // Vertical drift beyond the limit spoils the sweep
    report(1'b1, '0, 12'd2500, 10000);
    report(1'b1, '1, 12'd2701, 10000);
    report(1'b0, '0, '0, 10000);
    // Valid sweep, touched again back to down, valid again, then released
    report(1'b1, '0, '1, 10000);
    report(1'b1, '1, '1, 20000);
    report(1'b1, 12'd2000, 12'd4000, 20000);
    report(1'b1, '1, 12'd3900, 20000);
    report(1'b0, '0, '0, 20000);
    // Second tap near the first that also sweeps: both fire on release
    report(1'b1, 12'd100, 12'd4000, 50000);
    report(1'b1, '1, 12'd4000, 10000);
    report(1'b0, '0, '0, 40000);
  endtask

  task automatic test_failed_taps();
    configure(12'd1080, 12'd1920, 1'b0, 1'b1, 1'b0);
    report(1'b1, 12'd500, 12'd1500, 300000);
    report(1'b0, '0, '0, 50000);
    // Second tap too far: becomes a new first tap
    report(1'b1, 12'd800, 12'd1500, 50000);
    report(1'b0, '0, '0, 50000);
    // Second tap released too late: back to the up phase
    report(1'b1, 12'd810, 12'd1510, 50000);
    report(1'b0, '0, '0, 300000);
    // Timestamp going backwards reads as a huge delay
    now_us = now_us - stamp_t'(1000);
    report(1'b1, 12'd812, 12'd1512, 0);
    // Too short a press, then a touch in the ignored upper half
    report(1'b0, '0, '0, 1000);
    report(1'b1, 12'd812, '0, 10000);
  endtask

  // Zero resolution: any movement sweeps and every touch is in tap range
  task automatic test_zero_resolution();
    configure('0, '0, 1'b1, 1'b1, 1'b1);
    report(1'b1, 12'd10, '0, 300000);
    report(1'b1, 12'd11, '0, 10000);
    report(1'b0, '0, '0, 10000);
  endtask

  task automatic test_random_gestures();
    int unsigned phase, first, pick;
    coord_t      w, h;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          w = '0;
          h = '0;
        end
        1: begin
          w = '1;
          h = '1;
        end
        default: begin
          w = pick_resolution();
          h = pick_resolution();
        end
      endcase
      // Every third phase runs with no gaps and no stalls
      jitter = (phase % 3 != 2);
      configure(w, h, phase % 4 != 1, phase % 4 != 2, 1'($urandom_range(0, 1)));
      first = reports_sent;
      while (reports_sent - first < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) random_sweep();
        else if (pick < 8) random_double_tap();
        else random_noise();
      end
    end
  endtask

  // Sequence the tests
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    jitter = 1'b1;
    test_disabled_after_reset();
    test_sweep_and_double_tap();
    test_failed_taps();
    test_zero_resolution();
    test_random_gestures();
    drain_reports();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
